// ----- rtl/cartesian_polar_converter_unit_macros.svh -----
// Assertion macros shared by the converter RTL.
`ifndef CARTESIAN_POLAR_CONVERTER_UNIT_MACROS_SVH
`define CARTESIAN_POLAR_CONVERTER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define CPC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define CPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/cpc_pkg.sv -----
// Types, constants and helper functions of the cartesian/polar converter.
package cpc_pkg;

    localparam int COORD_BITS   = 12;
    localparam int CORDIC_STEPS = 16;
    localparam int ANGLE_BITS   = 10;
    localparam int OUT_BITS     = 13;
    localparam int FRAC_BITS    = 16;
    localparam int TABLE_LEN    = 24;
    localparam int N_STEPS      = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

    // Datapath width: coordinate, fraction, CORDIC growth, sign and negation headroom.
    localparam int DATA_W = COORD_BITS + FRAC_BITS + 3;
    // Angle accumulator in Q16 degrees, covers +-180 plus the sum of the table.
    localparam int Z_W    = 27;
    localparam int PROD_W = DATA_W + 16;

    localparam int S_TDATA_W = ((3 * COORD_BITS + ANGLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 * OUT_BITS + 7) / 8) * 8;

    localparam logic [15:0] GAIN_Q16 = 16'd39797;

    typedef enum logic {
        KIND_TO_POLAR = 1'b0,
        KIND_TO_CART  = 1'b1
    } cpc_kind_t;

    typedef struct packed {
        cpc_kind_t                 kind;
        logic                      flip;
        logic                      origin;
        logic signed [DATA_W-1:0]  x;
        logic signed [DATA_W-1:0]  y;
        logic signed [Z_W-1:0]     z;
    } cpc_item_t;

    // atan(2^-idx) in degrees, Q16.
    function automatic logic signed [Z_W-1:0] atan_q16(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:       v = Z_W'(2949120);
            1:       v = Z_W'(1740967);
            2:       v = Z_W'(919879);
            3:       v = Z_W'(466945);
            4:       v = Z_W'(234379);
            5:       v = Z_W'(117304);
            6:       v = Z_W'(58666);
            7:       v = Z_W'(29335);
            8:       v = Z_W'(14668);
            9:       v = Z_W'(7334);
            10:      v = Z_W'(3667);
            11:      v = Z_W'(1833);
            12:      v = Z_W'(917);
            13:      v = Z_W'(458);
            14:      v = Z_W'(229);
            15:      v = Z_W'(115);
            16:      v = Z_W'(57);
            17:      v = Z_W'(29);
            18:      v = Z_W'(14);
            19:      v = Z_W'(7);
            20:      v = Z_W'(4);
            21:      v = Z_W'(2);
            22:      v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Q16 to integer, truncated toward zero.
    function automatic logic signed [DATA_W-1:0] q16_trunc(input logic signed [DATA_W-1:0] v);
        logic signed [DATA_W-1:0] b;
        b = v + {{(DATA_W-FRAC_BITS){1'b0}}, {FRAC_BITS{v[DATA_W-1]}}};
        return b >>> FRAC_BITS;
    endfunction

    // Clamp to the output range.
    function automatic logic signed [OUT_BITS-1:0] sat_out(input logic signed [DATA_W-1:0] v);
        logic signed [DATA_W-1:0] hi;
        logic signed [DATA_W-1:0] lo;
        hi = DATA_W'((1 <<< (OUT_BITS - 1)) - 1);
        lo = -hi - DATA_W'(1);
        if (v > hi) begin
            return hi[OUT_BITS-1:0];
        end else if (v < lo) begin
            return lo[OUT_BITS-1:0];
        end
        return v[OUT_BITS-1:0];
    endfunction

endpackage

// ----- rtl/cpc_prep.sv -----
// Input stage: quadrant and angle reduction, gain scaling, Q16 start values.
`include "cartesian_polar_converter_unit_macros.svh"

module cpc_prep import cpc_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  cpc_kind_t                     in_kind,
    input  logic signed [COORD_BITS-1:0]  coord_x,
    input  logic signed [COORD_BITS-1:0]  coord_y,
    input  logic        [COORD_BITS-1:0]  radius_in,
    input  logic signed [ANGLE_BITS-1:0]  angle_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output cpc_item_t                     out_item
);

    localparam logic signed [Z_W-1:0]      Z_180   = Z_W'(180 * 65536);
    localparam logic signed [Z_W-1:0]      Z_90    = Z_W'(90 * 65536);
    localparam logic signed [ANGLE_BITS:0] DEG_90  = (ANGLE_BITS + 1)'(90);
    localparam logic signed [ANGLE_BITS:0] DEG_180 = (ANGLE_BITS + 1)'(180);
    localparam logic signed [ANGLE_BITS:0] DEG_360 = (ANGLE_BITS + 1)'(360);

    logic      valid_reg;
    cpc_item_t item_reg;
    cpc_item_t item_next;

    logic signed [DATA_W-1:0]       xe;
    logic signed [DATA_W-1:0]       ye;
    logic signed [DATA_W-1:0]       x0;
    logic signed [DATA_W-1:0]       y0;
    logic                           neg;
    logic signed [ANGLE_BITS:0]     a0;
    logic signed [ANGLE_BITS:0]     a1;
    logic signed [ANGLE_BITS:0]     a2;
    logic                           fold;
    logic        [COORD_BITS+15:0]  r_prod;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb begin
        // cartesian side: mirror the left half plane, start the angle at +-180
        xe  = DATA_W'(coord_x);
        ye  = DATA_W'(coord_y);
        neg = coord_x[COORD_BITS-1];
        x0  = neg ? -xe : xe;
        y0  = neg ? -ye : ye;

        // polar side: wrap into -179..180, then fold into -90..90
        a0 = (ANGLE_BITS + 1)'(angle_in);
        if (a0 > DEG_180) begin
            a1 = a0 - DEG_360;
        end else if (a0 <= -DEG_180) begin
            a1 = a0 + DEG_360;
        end else begin
            a1 = a0;
        end
        fold = 1'b0;
        a2   = a1;
        if (a1 > DEG_90) begin
            a2   = a1 - DEG_180;
            fold = 1'b1;
        end else if (a1 < -DEG_90) begin
            a2   = a1 + DEG_180;
            fold = 1'b1;
        end
        r_prod = (COORD_BITS + 16)'(radius_in) * (COORD_BITS + 16)'(GAIN_Q16);

        item_next.kind = in_kind;
        if (in_kind == KIND_TO_POLAR) begin
            item_next.flip   = 1'b0;
            item_next.origin = (coord_x == '0) && (coord_y == '0);
            item_next.x      = x0 <<< FRAC_BITS;
            item_next.y      = y0 <<< FRAC_BITS;
            if (!neg) begin
                item_next.z = '0;
            end else if (coord_y[COORD_BITS-1]) begin
                item_next.z = -Z_180;
            end else begin
                item_next.z = Z_180;
            end
        end else begin
            item_next.flip   = fold;
            item_next.origin = 1'b0;
            item_next.x      = DATA_W'(r_prod);
            item_next.y      = '0;
            item_next.z      = Z_W'(a2) <<< FRAC_BITS;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    `CPC_ASSERT_IMPL(a_origin_polar_only, valid_reg && item_reg.origin,
        item_reg.kind == KIND_TO_POLAR, "origin flag on a polar-to-cartesian item")
    `CPC_ASSERT_IMPL(a_vector_x_nonneg, valid_reg && item_reg.kind == KIND_TO_POLAR,
        !item_reg.x[DATA_W-1], "vectoring start x is negative")
    `CPC_ASSERT_IMPL(a_rotate_range, valid_reg && item_reg.kind == KIND_TO_CART,
        item_reg.z <= Z_90 && item_reg.z >= -Z_90 && item_reg.y == '0,
        "rotation start out of range")
    `CPC_ASSERT_NEXT(a_load_kind, in_valid && in_ready && in_kind == KIND_TO_CART,
        valid_reg && item_reg.kind == KIND_TO_CART, "accepted beat not loaded")

endmodule

// ----- rtl/cpc_cordic.sv -----
// CORDIC iteration pipeline, one register stage per iteration.
module cpc_cordic import cpc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  cpc_item_t  in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output cpc_item_t  out_item
);

    cpc_item_t stage_reg [N_STEPS];
    logic      valid_reg [N_STEPS];
    logic      stage_rdy [N_STEPS];

    for (genvar i = 0; i < N_STEPS; i++) begin : g_step
        cpc_item_t               up_item;
        logic                    up_valid;
        logic                    down_ready;
        cpc_item_t               stage_next;
        logic                    plus;
        logic signed [DATA_W-1:0] xs;
        logic signed [DATA_W-1:0] ys;

        if (i == 0) begin : g_first
            assign up_item  = in_item;
            assign up_valid = in_valid;
        end else begin : g_mid
            assign up_item  = stage_reg[i-1];
            assign up_valid = valid_reg[i-1];
        end

        if (i == N_STEPS - 1) begin : g_last
            assign down_ready = out_ready;
        end else begin : g_inner
            assign down_ready = stage_rdy[i+1];
        end

        assign stage_rdy[i] = !valid_reg[i] || down_ready;

        always_comb begin
            // vectoring drives y to zero, rotation drives z to zero
            if (up_item.kind == KIND_TO_POLAR) begin
                plus = up_item.y[DATA_W-1];
            end else begin
                plus = !up_item.z[Z_W-1];
            end
            xs = up_item.x >>> i;
            ys = up_item.y >>> i;
            stage_next = up_item;
            if (plus) begin
                stage_next.x = up_item.x - ys;
                stage_next.y = up_item.y + xs;
                stage_next.z = up_item.z - atan_q16(i);
            end else begin
                stage_next.x = up_item.x + ys;
                stage_next.y = up_item.y - xs;
                stage_next.z = up_item.z + atan_q16(i);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (stage_rdy[i]) begin
                valid_reg[i] <= up_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_rdy[i] && up_valid) begin
                stage_reg[i] <= stage_next;
            end
        end
    end

    assign in_ready  = stage_rdy[0];
    assign out_valid = valid_reg[N_STEPS-1];
    assign out_item  = stage_reg[N_STEPS-1];

endmodule

// ----- rtl/cpc_post.sv -----
// Output stages: gain multiply, truncation, clamping and result selection.
module cpc_post import cpc_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  cpc_item_t                    in_item,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [OUT_BITS-1:0]   first_value,
    output logic signed [OUT_BITS-1:0]   second_value,
    output logic                         angle_undefined
);

    typedef struct packed {
        cpc_kind_t                 kind;
        logic                      origin;
        logic        [PROD_W-1:0]  prod;
        logic signed [DATA_W-1:0]  tx;
        logic signed [DATA_W-1:0]  ty;
        logic signed [DATA_W-1:0]  ta;
    } post_item_t;

    localparam logic signed [DATA_W-1:0] DEG_180 = DATA_W'(180);

    logic       a_valid_reg;
    post_item_t a_reg;
    post_item_t a_next;
    logic       a_ready;

    logic                        b_valid_reg;
    logic signed [OUT_BITS-1:0]  first_reg;
    logic signed [OUT_BITS-1:0]  second_reg;
    logic                        flag_reg;
    logic signed [OUT_BITS-1:0]  first_next;
    logic signed [OUT_BITS-1:0]  second_next;
    logic                        b_ready;

    logic        [DATA_W-1:0]    x_pos;
    logic signed [DATA_W-1:0]    xf;
    logic signed [DATA_W-1:0]    yf;
    logic signed [DATA_W-1:0]    radius;
    logic signed [DATA_W-1:0]    angle;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb begin
        // negative final x cannot carry a radius; clamp to zero
        x_pos = in_item.x[DATA_W-1] ? '0 : in_item.x;
        xf    = in_item.flip ? -in_item.x : in_item.x;
        yf    = in_item.flip ? -in_item.y : in_item.y;

        a_next.kind   = in_item.kind;
        a_next.origin = in_item.origin;
        a_next.prod   = PROD_W'(x_pos) * PROD_W'(GAIN_Q16);
        a_next.tx     = q16_trunc(xf);
        a_next.ty     = q16_trunc(yf);
        a_next.ta     = q16_trunc(DATA_W'(in_item.z));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_reg <= a_next;
        end
    end

    always_comb begin
        radius = DATA_W'(a_reg.prod >> 32);
        if (a_reg.ta > DEG_180) begin
            angle = DEG_180;
        end else if (a_reg.ta < -DEG_180) begin
            angle = -DEG_180;
        end else begin
            angle = a_reg.ta;
        end

        if (a_reg.origin) begin
            first_next  = '0;
            second_next = '0;
        end else if (a_reg.kind == KIND_TO_POLAR) begin
            first_next  = sat_out(radius);
            second_next = sat_out(angle);
        end else begin
            first_next  = sat_out(a_reg.tx);
            second_next = sat_out(a_reg.ty);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_ready && a_valid_reg) begin
            first_reg  <= first_next;
            second_reg <= second_next;
            flag_reg   <= a_reg.origin;
        end
    end

    assign out_valid       = b_valid_reg;
    assign first_value     = first_reg;
    assign second_value    = second_reg;
    assign angle_undefined = flag_reg;

endmodule

// ----- rtl/cartesian_polar_converter_unit.sv -----
// Converter between integer cartesian points and radius/degree pairs: one beat
// per clock cycle sustained while m_tready is high, with one input stage, one
// CORDIC stage per iteration and two output stages. Each stage holds its beat
// while the next one is full, so the input keeps taking beats while a result
// waits on the output, until every stage is full. Kind 0 returns radius and
// angle (-180..180) and flags the origin; kind 1 returns x and y. Values are
// truncated toward zero and saturated to 13 bits.
`include "cartesian_polar_converter_unit_macros.svh"

module cartesian_polar_converter_unit import cpc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // coord_x, coord_y, radius_in, angle_in, zero pad
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // kind
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // first_value, second_value, zero pad
    output logic [M_TDATA_W-1:0]  m_tdata,
    // angle_undefined
    output logic                  m_tuser
);

    logic      prep_valid;
    logic      prep_ready;
    cpc_item_t prep_item;
    logic      core_valid;
    logic      core_ready;
    cpc_item_t core_item;

    logic signed [OUT_BITS-1:0] first_value;
    logic signed [OUT_BITS-1:0] second_value;

    cpc_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (cpc_kind_t'(s_tuser)),
        .coord_x   (s_tdata[COORD_BITS-1:0]),
        .coord_y   (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .radius_in (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .angle_in  (s_tdata[3*COORD_BITS+ANGLE_BITS-1:3*COORD_BITS]),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_item  (prep_item)
    );

    cpc_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_item   (prep_item),
        .out_valid (core_valid),
        .out_ready (core_ready),
        .out_item  (core_item)
    );

    cpc_post u_post (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (core_valid),
        .in_ready        (core_ready),
        .in_item         (core_item),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .first_value     (first_value),
        .second_value    (second_value),
        .angle_undefined (m_tuser)
    );

    assign m_tdata = {{(M_TDATA_W - 2 * OUT_BITS){1'b0}}, second_value, first_value};

    `CPC_ASSERT_IMPL(a_origin_zero, m_tvalid && m_tuser, first_value == '0 && second_value == '0, "origin beat with nonzero values")

endmodule
